// ----- design/wnes_pkg.sv -----
// Package for the weighted nearest entry select block.
// Holds the sequencer state type, field widths and arithmetic constants.
// No dependencies.
`default_nettype none

package wnes_pkg;

  // Entry fields as stored in one table word
  localparam int unsigned ID_W     = 16;
  localparam int unsigned MASK_W   = 32;
  localparam int unsigned VAL_W    = 16;
  localparam int unsigned SCORE_W  = 32;
  localparam int unsigned ENTRY_W  = ID_W + MASK_W + 6 * VAL_W;
  localparam int unsigned MASK_LSB = ID_W;
  localparam int unsigned TGT_LSB  = ID_W + MASK_W;
  localparam int unsigned WID_LSB  = ID_W + MASK_W + 3 * VAL_W;

  // Slot index width on the ports
  localparam int unsigned IDX_W = 6;

  // Action codes carried on in_tuser
  localparam logic ACT_LOAD  = 1'b0;
  localparam logic ACT_QUERY = 1'b1;

  // Smallest tolerance, Q4.12 (about 0.001)
  localparam logic [VAL_W-1:0] MIN_WIDTH = 16'd4;

  // Saturated score
  localparam logic [SCORE_W-1:0] SCORE_MAX = 32'hFFFF_FFFF;

  // Query sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RD,
    ST_CHK,
    ST_SQD,
    ST_SQW,
    ST_DIV,
    ST_ACC,
    ST_CMP,
    ST_DONE
  } state_t;

endpackage

`default_nettype wire

// ----- design/wnes_ram.sv -----
// Generic single write, single read RAM with registered read data.
// Depends on nothing.
`default_nettype none

module wnes_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                                   clk,
  input  wire logic                                   we,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                       wdata,
  input  wire logic                                   re,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ----- design/weighted_nearest_entry_select_core.sv -----
// Weighted nearest entry select: table of entries and a query sequencer.
// Depends on wnes_pkg and wnes_ram.
//
// Usage:
//   Input channel (in_*): one beat is a load (in_tuser = 0) or a query
//   (in_tuser = 1). A load writes all fields of one slot in the accepting
//   cycle; the block is ready again in the next cycle. A query scans the
//   table slot by slot and returns one result beat on out_*.
//   A query skips an unused slot, reads and drops a slot whose mask lacks
//   the class, and scores each qualifying slot. The qualifying slots
//   dominate: each runs three terms through one shared 16x16 multiplier
//   (two products) and one radix-2 divider (32 steps). The block takes no
//   input beat while a query runs.
//   Result: out_tuser = found; out_tdata carries index, id and score.
//   A result waits in the output register while the receiver stalls; the
//   block still takes loads and a new query then, and a later query holds
//   at its end until the output register is free.
//   Reset clears every slot to unused through per-slot valid bits and
//   drops any pending result. No clearing pass is needed.
`default_nettype none

module weighted_nearest_entry_select_core #(
  parameter int unsigned TABLE_DEPTH = 64
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  // in_tdata, lowest bit first: entry_index[6], entry_id[16], class_mask[32],
  // planet_class[5], temperature[16], moisture[16], elevation[16],
  // temperature_width[16], moisture_width[16], elevation_width[16], zero pad
  input  wire logic [159:0] in_tdata,
  // in_tuser: action (0 load, 1 query)
  input  wire logic [0:0]   in_tuser,
  output logic              out_tvalid,
  input  wire logic         out_tready,
  // out_tdata, lowest bit first: best_index[6], best_id[16], best_score[32],
  // zero pad
  output logic [55:0]       out_tdata,
  // out_tuser: found
  output logic [0:0]        out_tuser
);

  // Only the first 64 slots can ever be loaded
  localparam int unsigned EFF = (TABLE_DEPTH < 64) ? TABLE_DEPTH : 64;
  localparam int unsigned AW  = (EFF > 1) ? $clog2(EFF) : 1;

  // Input fields
  logic [5:0]  in_idx;
  logic [15:0] in_id;
  logic [31:0] in_mask;
  logic [4:0]  in_cls;
  logic [47:0] in_vals;
  logic [47:0] in_wids;
  logic        in_acc;
  logic        ld_ok;

  assign in_idx  = in_tdata[5:0];
  assign in_id   = in_tdata[21:6];
  assign in_mask = in_tdata[53:22];
  assign in_cls  = in_tdata[58:54];
  assign in_vals = in_tdata[106:59];
  assign in_wids = in_tdata[154:107];
  assign in_acc  = in_tvalid && in_tready;
  assign ld_ok   = in_acc && (in_tuser[0] == wnes_pkg::ACT_LOAD) && (32'(in_idx) < EFF);

  // Sequencer and datapath registers
  wnes_pkg::state_t state_r, state_nxt;
  logic [AW-1:0]    cnt_r, cnt_nxt;
  logic [1:0]       k_r, k_nxt;
  logic [4:0]       div_cnt_r, div_cnt_nxt;
  logic [31:0]      num_r, num_nxt;
  logic [31:0]      den_r, den_nxt;
  logic [31:0]      rem_r, rem_nxt;
  logic [33:0]      sum_r, sum_nxt;
  logic [4:0]       cls_r;
  logic [47:0]      smp_r;
  logic             found_r, found_nxt;
  logic [AW-1:0]    best_idx_r, best_idx_nxt;
  logic [15:0]      best_id_r, best_id_nxt;
  logic [31:0]      best_score_r, best_score_nxt;
  logic [EFF-1:0]   valid_r;
  logic             out_valid_r;
  logic             out_found_r;
  logic [5:0]       out_idx_r;
  logic [15:0]      out_id_r;
  logic [31:0]      out_score_r;

  // Table memory
  logic [wnes_pkg::ENTRY_W-1:0] rd_data;
  logic                         rd_en;

  wnes_ram #(
    .WIDTH (wnes_pkg::ENTRY_W),
    .DEPTH (EFF)
  ) u_table (
    .clk   (clk),
    .we    (ld_ok),
    .waddr (in_idx[AW-1:0]),
    .wdata ({in_wids, in_vals, in_mask, in_id}),
    .re    (rd_en),
    .raddr (cnt_r),
    .rdata (rd_data)
  );

  // Fields of the slot under scan
  logic [15:0] ent_id;
  logic [31:0] ent_mask;
  logic [15:0] ent_tgt;
  logic [15:0] ent_wid;
  logic [15:0] smp;
  logic [15:0] wcl;
  logic [15:0] dif;
  logic        qual;
  logic        last;
  logic        slot_ok;
  logic [15:0] mul_a;
  logic [31:0] mul_p;
  logic [32:0] sh;
  logic        ge;
  logic [31:0] score;
  logic        better;
  logic        out_free;

  assign ent_id   = rd_data[wnes_pkg::ID_W-1:0];
  assign ent_mask = rd_data[wnes_pkg::MASK_LSB +: wnes_pkg::MASK_W];

  // Pick one of the three terms
  always_comb begin
    unique case (k_r)
      2'd1: begin
        ent_tgt = rd_data[wnes_pkg::TGT_LSB + 16 +: 16];
        ent_wid = rd_data[wnes_pkg::WID_LSB + 16 +: 16];
        smp     = smp_r[31:16];
      end
      2'd2: begin
        ent_tgt = rd_data[wnes_pkg::TGT_LSB + 32 +: 16];
        ent_wid = rd_data[wnes_pkg::WID_LSB + 32 +: 16];
        smp     = smp_r[47:32];
      end
      default: begin
        ent_tgt = rd_data[wnes_pkg::TGT_LSB +: 16];
        ent_wid = rd_data[wnes_pkg::WID_LSB +: 16];
        smp     = smp_r[15:0];
      end
    endcase
  end

  assign wcl     = (ent_wid < wnes_pkg::MIN_WIDTH) ? wnes_pkg::MIN_WIDTH : ent_wid;
  assign dif     = (smp >= ent_tgt) ? (smp - ent_tgt) : (ent_tgt - smp);
  assign qual    = ent_mask[cls_r];
  assign last    = (cnt_r == AW'(EFF - 1));
  assign slot_ok = valid_r[cnt_r];

  // Shared squaring multiplier
  assign mul_a = (state_r == wnes_pkg::ST_SQD) ? dif : wcl;
  assign mul_p = 32'(mul_a) * 32'(mul_a);

  // Divider step
  assign sh = {rem_r, num_r[31]};
  assign ge = sh >= {1'b0, den_r};

  // Saturate the score and compare against the best so far
  assign score  = (sum_r[33:32] != 2'd0) ? wnes_pkg::SCORE_MAX : sum_r[31:0];
  assign better = !found_r || (score < best_score_r) ||
                  ((score == best_score_r) && (ent_id < best_id_r));

  assign out_free = !out_valid_r || out_tready;

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      wnes_pkg::ST_IDLE: begin
        if (in_acc && (in_tuser[0] == wnes_pkg::ACT_QUERY)) begin
          state_nxt = wnes_pkg::ST_RD;
        end
      end
      wnes_pkg::ST_RD: begin
        if (slot_ok) begin
          state_nxt = wnes_pkg::ST_CHK;
        end else if (last) begin
          state_nxt = wnes_pkg::ST_DONE;
        end
      end
      wnes_pkg::ST_CHK: begin
        if (qual) begin
          state_nxt = wnes_pkg::ST_SQD;
        end else if (last) begin
          state_nxt = wnes_pkg::ST_DONE;
        end else begin
          state_nxt = wnes_pkg::ST_RD;
        end
      end
      wnes_pkg::ST_SQD: state_nxt = wnes_pkg::ST_SQW;
      wnes_pkg::ST_SQW: state_nxt = wnes_pkg::ST_DIV;
      wnes_pkg::ST_DIV: begin
        if (div_cnt_r == 5'd31) begin
          state_nxt = wnes_pkg::ST_ACC;
        end
      end
      wnes_pkg::ST_ACC: begin
        state_nxt = (k_r == 2'd2) ? wnes_pkg::ST_CMP : wnes_pkg::ST_SQD;
      end
      wnes_pkg::ST_CMP: begin
        state_nxt = last ? wnes_pkg::ST_DONE : wnes_pkg::ST_RD;
      end
      wnes_pkg::ST_DONE: begin
        if (out_free) begin
          state_nxt = wnes_pkg::ST_IDLE;
        end
      end
      default: state_nxt = wnes_pkg::ST_IDLE;
    endcase
  end

  // Datapath next values
  always_comb begin
    rd_en          = 1'b0;
    cnt_nxt        = cnt_r;
    k_nxt          = k_r;
    div_cnt_nxt    = div_cnt_r;
    num_nxt        = num_r;
    den_nxt        = den_r;
    rem_nxt        = rem_r;
    sum_nxt        = sum_r;
    found_nxt      = found_r;
    best_idx_nxt   = best_idx_r;
    best_id_nxt    = best_id_r;
    best_score_nxt = best_score_r;
    unique case (state_r)
      wnes_pkg::ST_IDLE: begin
        cnt_nxt        = '0;
        found_nxt      = 1'b0;
        best_idx_nxt   = '0;
        best_id_nxt    = '0;
        best_score_nxt = '0;
      end
      wnes_pkg::ST_RD: begin
        rd_en = slot_ok;
        k_nxt = 2'd0;
        sum_nxt = '0;
        if (!slot_ok && !last) begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      wnes_pkg::ST_CHK: begin
        if (!qual && !last) begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      wnes_pkg::ST_SQD: begin
        num_nxt = mul_p;
      end
      wnes_pkg::ST_SQW: begin
        den_nxt     = mul_p;
        rem_nxt     = '0;
        div_cnt_nxt = '0;
      end
      wnes_pkg::ST_DIV: begin
        rem_nxt     = ge ? 32'(sh - {1'b0, den_r}) : sh[31:0];
        num_nxt     = {num_r[30:0], ge};
        div_cnt_nxt = div_cnt_r + 1'b1;
      end
      wnes_pkg::ST_ACC: begin
        sum_nxt = sum_r + 34'(num_r);
        k_nxt   = k_r + 1'b1;
      end
      wnes_pkg::ST_CMP: begin
        if (better) begin
          found_nxt      = 1'b1;
          best_idx_nxt   = cnt_r;
          best_id_nxt    = ent_id;
          best_score_nxt = score;
        end
        if (!last) begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      wnes_pkg::ST_DONE: begin
      end
      default: begin
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= wnes_pkg::ST_IDLE;
      valid_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (ld_ok) begin
        valid_r[in_idx[AW-1:0]] <= (in_id != 16'd0);
      end
      if (state_r == wnes_pkg::ST_DONE && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    cnt_r        <= cnt_nxt;
    k_r          <= k_nxt;
    div_cnt_r    <= div_cnt_nxt;
    num_r        <= num_nxt;
    den_r        <= den_nxt;
    rem_r        <= rem_nxt;
    sum_r        <= sum_nxt;
    found_r      <= found_nxt;
    best_idx_r   <= best_idx_nxt;
    best_id_r    <= best_id_nxt;
    best_score_r <= best_score_nxt;
    if (in_acc && (in_tuser[0] == wnes_pkg::ACT_QUERY)) begin
      cls_r <= in_cls;
      smp_r <= in_vals;
    end
    if (state_r == wnes_pkg::ST_DONE && out_free) begin
      out_found_r <= found_r;
      out_idx_r   <= 6'(best_idx_r);
      out_id_r    <= best_id_r;
      out_score_r <= best_score_r;
    end
  end

  assign in_tready  = (state_r == wnes_pkg::ST_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, out_score_r, out_id_r, out_idx_r};
  assign out_tuser  = out_found_r;

endmodule

`default_nettype wire

// ----- design/wnes_chk.sv -----
// Port-level checker for the weighted nearest entry select core.
// Depends on wnes_pkg and weighted_nearest_entry_select_core (bound below).
`default_nettype none

module wnes_chk (
  input wire logic         clk,
  input wire logic         rst_n,
  input wire logic         in_tvalid,
  input wire logic         in_tready,
  input wire logic [0:0]   in_tuser,
  input wire logic         out_tvalid,
  input wire logic         out_tready,
  input wire logic [55:0]  out_tdata,
  input wire logic [0:0]   out_tuser
);

  // A stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result beat changed under stall");

  // An empty answer carries all-zero fields
  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser[0] |-> out_tdata == 56'd0)
    else $error("empty answer with nonzero fields");

  // A query beat makes the block busy
  a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && (in_tuser[0] == wnes_pkg::ACT_QUERY) |=> !in_tready)
    else $error("ready right after a query");

  // A load beat leaves the block ready
  a_load_ready: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && (in_tuser[0] == wnes_pkg::ACT_LOAD) |=> in_tready)
    else $error("not ready after a load");

endmodule

bind weighted_nearest_entry_select_core wnes_chk u_wnes_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tuser   (in_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

`default_nettype wire

// ----- tb/weighted_nearest_entry_select_core_tb.sv -----
// Testbench for weighted_nearest_entry_select_core: loads and queries on the input stream.
// Results are checked against a scoreboard that keeps its own copy of the entry table.
// Depends on wnes_pkg and the core RTL.
`default_nettype none

module weighted_nearest_entry_select_core_tb;

  localparam int unsigned DEPTH = 64;
  localparam int unsigned N_RANDOM = 1150;

  typedef struct packed {
    logic        action;
    logic [5:0]  slot;
    logic [15:0] id;
    logic [31:0] mask;
    logic [4:0]  cls;
    logic [15:0] temp;
    logic [15:0] moist;
    logic [15:0] elev;
    logic [15:0] temp_w;
    logic [15:0] moist_w;
    logic [15:0] elev_w;
  } beat_t;

  typedef struct packed {
    logic        found;
    logic [5:0]  slot;
    logic [15:0] id;
    logic [31:0] score;
  } answer_t;

  // Scoreboard: shadow entry table and queue of pending answers
  class nearest_scoreboard;
    logic [15:0] ent_id [DEPTH];
    logic [31:0] ent_mask [DEPTH];
    logic [15:0] ent_tgt [DEPTH][3];
    logic [15:0] ent_wid [DEPTH][3];
    answer_t     pending_answers[$];
    int          n_errors;
    int          n_loads;
    int          n_queries;
    int          n_found;

    function new();
      for (int i = 0; i < DEPTH; i++) begin
        ent_id[i] = '0;
        ent_mask[i] = '0;
        for (int k = 0; k < 3; k++) begin
          ent_tgt[i][k] = '0;
          ent_wid[i][k] = '0;
        end
      end
      n_errors = 0;
      n_loads = 0;
      n_queries = 0;
      n_found = 0;
    endfunction

    function longint unsigned weighted_term(logic [15:0] s, logic [15:0] t,
                                            logic [15:0] w);
      longint unsigned d;
      longint unsigned ww;
      d  = 64'((s >= t) ? s - t : t - s);
      ww = 64'((w < wnes_pkg::MIN_WIDTH) ? wnes_pkg::MIN_WIDTH : w);
      return (d * d) / (ww * ww);
    endfunction

    // Apply a load to the shadow table or queue the answer of a query
    function void note_input(beat_t b);
      logic [15:0] samp[3];
      answer_t     ans;
      longint unsigned sc;
      samp[0] = b.temp;
      samp[1] = b.moist;
      samp[2] = b.elev;
      if (b.action == wnes_pkg::ACT_LOAD) begin
        n_loads++;
        ent_id[b.slot]   = b.id;
        ent_mask[b.slot] = b.mask;
        for (int k = 0; k < 3; k++) ent_tgt[b.slot][k] = samp[k];
        ent_wid[b.slot][0] = b.temp_w;
        ent_wid[b.slot][1] = b.moist_w;
        ent_wid[b.slot][2] = b.elev_w;
        return;
      end
      n_queries++;
      ans = '0;
      for (int i = 0; i < DEPTH; i++) begin
        if (ent_id[i] == 0 || ent_mask[i][b.cls] == 1'b0) continue;
        sc = 0;
        for (int k = 0; k < 3; k++) sc += weighted_term(samp[k], ent_tgt[i][k], ent_wid[i][k]);
        if (sc > 64'hFFFF_FFFF) sc = 64'hFFFF_FFFF;
        if (!ans.found || sc < ans.score || (sc == ans.score && ent_id[i] < ans.id)) begin
          ans.found = 1'b1;
          ans.slot  = i[5:0];
          ans.id    = ent_id[i];
          ans.score = sc[31:0];
        end
      end
      if (ans.found) n_found++;
      pending_answers.push_back(ans);
    endfunction

    task report(string what, logic [31:0] got, logic [31:0] want);
      $display("MISMATCH %s: got %0h, expected %0h at %0t", what, got, want, $realtime);
      n_errors++;
    endtask

    // Compare one result beat with the oldest pending answer
    task check_result(answer_t got);
      answer_t want;
      if (pending_answers.size() == 0) begin
        report("unexpected result beat", 32'(got.id), 32'd0);
        return;
      end
      want = pending_answers.pop_front();
      if (got.found !== want.found) report("found", 32'(got.found), 32'(want.found));
      if (got.slot !== want.slot) report("best_index", 32'(got.slot), 32'(want.slot));
      if (got.id !== want.id) report("best_id", 32'(got.id), 32'(want.id));
      if (got.score !== want.score) report("best_score", got.score, want.score);
    endtask
  endclass

  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [159:0] in_tdata;
  logic [0:0]   in_tuser;
  logic         out_tvalid;
  logic         out_tready;
  logic [55:0]  out_tdata;
  logic [0:0]   out_tuser;

  nearest_scoreboard sb;
  bit  send_busy_mode;
  bit  recv_busy_mode;

  weighted_nearest_entry_select_core u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Present one beat, hold until accepted, then idle for the given gap
  task send_beat(beat_t b, int gap);
    bit ok;
    in_tvalid <= 1'b1;
    in_tuser  <= b.action;
    in_tdata  <= {5'd0, b.elev_w, b.moist_w, b.temp_w, b.elev, b.moist, b.temp,
                  b.cls, b.mask, b.id, b.slot};
    do begin
      @(negedge clk);
      ok = in_tready;
      @(posedge clk);
    end while (!ok);
    sb.note_input(b);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  function int draw_gap(bit busy);
    if (!busy) return 0;
    return $urandom_range(0, 16);
  endfunction

  function beat_t make_load(logic [5:0] slot, logic [15:0] id, logic [31:0] mask,
                            logic [15:0] tv, logic [15:0] wv);
    beat_t b;
    b = '0;
    b.action = wnes_pkg::ACT_LOAD;
    b.slot = slot;
    b.id = id;
    b.mask = mask;
    b.temp = tv;
    b.moist = tv;
    b.elev = tv;
    b.temp_w = wv;
    b.moist_w = wv;
    b.elev_w = wv;
    return b;
  endfunction

  function beat_t make_query(logic [4:0] cls, logic [15:0] sv);
    beat_t b;
    b = '0;
    b.action = wnes_pkg::ACT_QUERY;
    b.cls = cls;
    b.temp = sv;
    b.moist = sv;
    b.elev = sv;
    return b;
  endfunction

  function logic [15:0] rand_width();
    if ($urandom_range(0, 9) == 0) return 16'($urandom_range(0, 3));
    return 16'($urandom());
  endfunction

  // Random beat: sparse masks keep the number of qualifying slots per query small
  function beat_t make_random();
    beat_t b;
    int    pick;
    int    src;
    b = '0;
    b.action = $urandom_range(0, 99) < 55 ? wnes_pkg::ACT_QUERY : wnes_pkg::ACT_LOAD;
    src = $urandom_range(0, DEPTH - 1);
    if (b.action == wnes_pkg::ACT_LOAD) begin
      b.slot = 6'($urandom_range(0, DEPTH - 1));
      pick = $urandom_range(0, 99);
      if (pick < 15) b.id = '0;
      else if (pick < 40) b.id = 16'($urandom_range(1, 4));
      else b.id = 16'($urandom());
      pick = $urandom_range(0, 99);
      if (pick < 80) b.mask = 32'd1 << $urandom_range(0, 31);
      else if (pick < 90) b.mask = (32'd1 << $urandom_range(0, 31)) |
                                   (32'd1 << $urandom_range(0, 31));
      else if (pick < 95) b.mask = '0;
      else b.mask = $urandom();
      // Sometimes copy another slot's targets to provoke equal scores
      if ($urandom_range(0, 3) == 0) begin
        b.temp  = sb.ent_tgt[src][0];
        b.moist = sb.ent_tgt[src][1];
        b.elev  = sb.ent_tgt[src][2];
        b.temp_w  = sb.ent_wid[src][0];
        b.moist_w = sb.ent_wid[src][1];
        b.elev_w  = sb.ent_wid[src][2];
      end else begin
        b.temp  = 16'($urandom());
        b.moist = 16'($urandom());
        b.elev  = 16'($urandom());
        b.temp_w  = rand_width();
        b.moist_w = rand_width();
        b.elev_w  = rand_width();
      end
    end else begin
      b.cls = 5'($urandom_range(0, 31));
      // Aim at a loaded slot's class and targets now and then
      if ($urandom_range(0, 1) == 0 && sb.ent_id[src] != 0 && sb.ent_mask[src] != 0) begin
        do b.cls = 5'($urandom_range(0, 31)); while (!sb.ent_mask[src][b.cls]);
        b.temp  = 16'(sb.ent_tgt[src][0] + $urandom_range(0, 7));
        b.moist = sb.ent_tgt[src][1];
        b.elev  = 16'(sb.ent_tgt[src][2] - $urandom_range(0, 3));
      end else begin
        b.temp  = 16'($urandom());
        b.moist = 16'($urandom());
        b.elev  = 16'($urandom());
      end
    end
    return b;
  endfunction

  // Result side: stall at random, check each accepted beat
  initial begin
    bit      ok;
    answer_t got;
    out_tready = 1'b0;
    @(posedge rst_n);
    forever begin
      int stall;
      stall = draw_gap(recv_busy_mode);
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      do begin
        @(negedge clk);
        ok = out_tvalid;
        got.found = out_tuser[0];
        got.slot  = out_tdata[5:0];
        got.id    = out_tdata[21:6];
        got.score = out_tdata[53:22];
        @(posedge clk);
      end while (!ok);
      sb.check_result(got);
    end
  end

  // Main stimulus
  initial begin
    beat_t b;
    int    wait_cnt;
    sb = new();
    send_busy_mode = 1'b1;
    recv_busy_mode = 1'b1;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty table, minimum widths, tie on score and id, extremes, id-zero loads
    send_beat(make_query(5'd0, 16'h0000), 0);
    send_beat(make_load(6'd0, 16'd5, 32'hFFFF_FFFF, 16'h0000, 16'd0), 1);
    send_beat(make_load(6'd63, 16'd5, 32'hFFFF_FFFF, 16'h0000, 16'd3), 0);
    send_beat(make_query(5'd31, 16'h0000), 2);
    send_beat(make_query(5'd0, 16'hFFFF), 0);
    send_beat(make_load(6'd10, 16'hFFFF, 32'h8000_0000, 16'hFFFF, 16'hFFFF), 0);
    send_beat(make_load(6'd20, 16'd1, 32'h0000_0001, 16'h8000, 16'h1000), 3);
    send_beat(make_query(5'd31, 16'hFFFF), 0);
    send_beat(make_query(5'd0, 16'h8000), 0);
    send_beat(make_query(5'd7, 16'h1234), 0);
    send_beat(make_load(6'd0, 16'd0, 32'h0000_0000, 16'h5555, 16'hAAAA), 0);
    send_beat(make_query(5'd5, 16'h0000), 0);
    send_beat(make_load(6'd63, 16'd0, 32'h0, 16'h0, 16'h0), 0);
    send_beat(make_load(6'd10, 16'd0, 32'h0, 16'h0, 16'h0), 0);
    send_beat(make_load(6'd20, 16'd0, 32'h0, 16'h0, 16'h0), 0);
    send_beat(make_query(5'd0, 16'h8000), 0);

    // Random part, switching between busy and free-running stretches
    for (int n = 0; n < N_RANDOM; n++) begin
      if (n % 100 == 0) begin
        send_busy_mode = $urandom_range(0, 3) != 0;
        recv_busy_mode = $urandom_range(0, 3) != 0;
      end
      b = make_random();
      send_beat(b, draw_gap(send_busy_mode));
    end
    in_tvalid <= 1'b0;

    // Drain outstanding answers, then a short settle
    wait_cnt = 0;
    while (sb.pending_answers.size() != 0 && wait_cnt < 200000) begin
      @(posedge clk);
      wait_cnt++;
    end
    repeat (200) @(posedge clk);

    $display("Covered %0d loads and %0d queries, %0d queries found an entry.",
             sb.n_loads, sb.n_queries, sb.n_found);
    if (sb.n_errors == 0 && sb.pending_answers.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Answers still pending: %0d, mismatches: %0d",
               sb.pending_answers.size(), sb.n_errors);
      $display("Test completed with failures");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #500000000;
    $display("Timeout waiting for the block");
    $display("Test completed with failures");
    $finish;
  end

endmodule

`default_nettype wire
